[rtl/rlte_pkg.sv]
// Shared types and constants for the run-length text encoder.
`default_nettype none

package rlte_pkg;

  localparam int          NUM_DIGITS = 5;
  localparam int          DIG_IDX_W  = 3;
  localparam int unsigned DIGIT_CAP  = 99999;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       string_done;
  } out_t;

  typedef struct packed {
    logic capture;
    logic advance_run;
    logic start_run;
    logic clear_run;
    logic emit_byte;
    logic emit_digit;
    logic mark_item_end;
    logic mark_string_end;
  } rlte_cmd_t;

  typedef struct packed {
    logic close_run;
    logic eos;
    logic digit_last;
    logic out_free;
  } rlte_sts_t;

endpackage

`default_nettype wire

[rtl/rlte_dp.sv]
// Datapath: held item, open run (binary and BCD length), digit pointer, output register.
`default_nettype none

module rlte_dp
  import rlte_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire            clk,
  input  wire            rst,
  input  wire in_t       item,
  input  wire rlte_cmd_t cmd,
  output rlte_sts_t      sts,
  input  wire            result_ready,
  output logic           result_valid,
  output out_t           result
);

  localparam int LEN_W = (COUNT_WIDTH < 17) ? COUNT_WIDTH : 17;
  localparam logic [63:0] MAX_WIDE = (COUNT_WIDTH < 17) ?
                                     ((64'd1 << COUNT_WIDTH) - 64'd1) : 64'(DIGIT_CAP);
  localparam logic [LEN_W-1:0] MAX_RUN = MAX_WIDE[LEN_W-1:0];

  in_t                  hold;
  logic [7:0]           run_byte;
  logic [LEN_W-1:0]     run_len;
  logic [3:0]           bcd [NUM_DIGITS];
  logic [3:0]           bcd_plus [NUM_DIGITS];
  logic [DIG_IDX_W-1:0] ndig;
  logic [DIG_IDX_W-1:0] ndig_plus;
  logic [DIG_IDX_W-1:0] didx;
  logic                 carry;

  // BCD increment of the run length, and its new digit count
  always_comb begin
    carry     = 1'b1;
    ndig_plus = ndig;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        bcd_plus[i] = (bcd[i] == 4'd9) ? 4'd0 : bcd[i] + 4'd1;
      end else begin
        bcd_plus[i] = bcd[i];
      end
      carry = carry && (bcd[i] == 4'd9);
    end
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_plus[i] != 4'd0) begin
        ndig_plus = DIG_IDX_W'(i + 1);
      end
    end
  end

  assign sts.close_run  = (run_len != '0) &&
                          ((hold.in_byte != run_byte) || (run_len >= MAX_RUN));
  assign sts.eos        = hold.end_of_string;
  assign sts.digit_last = (didx == '0);
  assign sts.out_free   = !result_valid || result_ready;

  // run state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      run_byte <= '0;
      run_len  <= '0;
      ndig     <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) bcd[i] <= '0;
    end else if (cmd.start_run || (cmd.advance_run && run_len == '0)) begin
      run_byte <= hold.in_byte;
      run_len  <= LEN_W'(1);
      ndig     <= DIG_IDX_W'(1);
      bcd[0]   <= 4'd1;
      for (int i = 1; i < NUM_DIGITS; i++) bcd[i] <= '0;
    end else if (cmd.advance_run) begin
      run_len <= run_len + LEN_W'(1);
      ndig    <= ndig_plus;
      for (int i = 0; i < NUM_DIGITS; i++) bcd[i] <= bcd_plus[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_digit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold <= item;
    end
    if (cmd.emit_byte) begin
      result.out_byte     <= run_byte;
      result.last_of_item <= 1'b0;
      result.string_done  <= 1'b0;
      didx                <= ndig - DIG_IDX_W'(1);
    end else if (cmd.emit_digit) begin
      result.out_byte     <= ASCII_ZERO | {4'd0, bcd[didx]};
      result.last_of_item <= cmd.mark_item_end;
      result.string_done  <= cmd.mark_string_end;
      didx                <= didx - DIG_IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

[rtl/rlte_ctrl.sv]
// Controller: sequences capture, run update and serialization of a closed run.
`default_nettype none

module rlte_ctrl
  import rlte_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  input  wire            item_valid,
  output logic           item_ready,
  input  wire rlte_sts_t sts,
  output rlte_cmd_t      cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DECIDE,
    EMIT_BYTE,
    EMIT_DIGIT
  } state_t;

  state_t state;
  logic   final_pass;  // emitting the run that ends the string

  assign item_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.capture = item_valid;
      end
      DECIDE: begin
        cmd.advance_run = !sts.close_run;
      end
      EMIT_BYTE: begin
        cmd.emit_byte = sts.out_free;
      end
      EMIT_DIGIT: begin
        cmd.emit_digit      = sts.out_free;
        cmd.mark_item_end   = sts.digit_last && (final_pass || !sts.eos);
        cmd.mark_string_end = sts.digit_last && final_pass;
        cmd.clear_run       = sts.out_free && sts.digit_last && final_pass;
        cmd.start_run       = sts.out_free && sts.digit_last && !final_pass;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      final_pass <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (item_valid) state <= DECIDE;
        end
        DECIDE: begin
          if (sts.close_run) begin
            final_pass <= 1'b0;
            state      <= EMIT_BYTE;
          end else if (sts.eos) begin
            final_pass <= 1'b1;
            state      <= EMIT_BYTE;
          end else begin
            state <= IDLE;
          end
        end
        EMIT_BYTE: begin
          if (sts.out_free) state <= EMIT_DIGIT;
        end
        EMIT_DIGIT: begin
          if (sts.out_free && sts.digit_last) begin
            if (!final_pass && sts.eos) begin
              // old run out; now flush the fresh one-byte run
              final_pass <= 1'b1;
              state      <= EMIT_BYTE;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/run_length_text_encoder.sv]
// Top level of the run-length text encoder.
//
// Input channel item/item_valid/item_ready carries one byte of a string per
// beat; end_of_string marks the last byte. Output channel result/
// result_valid/result_ready carries encoded bytes: a run's byte followed by
// the ASCII decimal digits of its length, no leading zeros.
// A byte that extends or starts a run is captured when idle, then updates the
// run in the decide state; item_ready is high only when idle, so a beat
// waits until the last is through. Closing a run sends its bytes (1 + digit
// count, at most 6) through the single output register; a byte that closes
// a run and also ends the string emits two runs back to back. A beat's final
// result may still wait in the output register while the next beat is taken.
// Runs are capped at 2^COUNT_WIDTH-1 (at most 99999); a longer run is split.
// When the receiver stalls, the controller holds its place until the output
// register is free; nothing is dropped. Synchronous reset empties the output
// register, clears the open run and returns the controller to idle.
`default_nettype none

module run_length_text_encoder
  import rlte_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire      clk,
  input  wire      rst,
  input  wire      item_valid,
  output logic     item_ready,
  input  wire in_t item,
  output logic     result_valid,
  input  wire      result_ready,
  output out_t     result
);

  rlte_cmd_t cmd;
  rlte_sts_t sts;

  rlte_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rlte_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

[verif/run_length_text_encoder_tb.sv]
// Self-checking testbench for run_length_text_encoder: random handshakes, run encoding predicted per beat.
`timescale 1ns / 100ps

module run_length_text_encoder_tb;
  import rlte_pkg::*;

  localparam int                   CNT_W    = 16;
  localparam longint unsigned      CNT_FULL = (64'd1 << CNT_W) - 1;
  localparam int unsigned          RUN_CAP  = (CNT_FULL > DIGIT_CAP) ? DIGIT_CAP : 32'(CNT_FULL);
  localparam int                   N_RANDOM = 360;

  typedef struct {
    in_t beat;
    bit  drain;  // hold this beat until every expected byte has come back
  } beat_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_t  item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result;

  beat_slot_t pending_beats[$];
  out_t       expected_bytes[$];
  out_t       beat_out[$];

  // encoder state as seen by the predictor
  logic [7:0]  run_char = 8'h00;
  int unsigned run_len = 0;

  int     errors = 0;
  longint cycle_count = 0;
  longint cycle_limit = 0;
  bit     beat_taken = 1'b0;
  bit     idle_en = 1'b1;
  int     send_gap = 0;
  int     recv_stall = 0;

  run_length_text_encoder #(.COUNT_WIDTH(CNT_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void add_beat(input logic [7:0] c, input bit eos, input bit drain);
    beat_slot_t s;
    s.beat.in_byte       = c;
    s.beat.end_of_string = eos;
    s.drain              = drain;
    pending_beats.insert(pending_beats.size(), s);
  endfunction

  // run byte, then decimal digits of the length, most significant first
  function automatic void emit_run();
    logic [7:0]  digs[$];
    int unsigned v;
    out_t        o;
    v = run_len;
    o = '0;
    o.out_byte = run_char;
    beat_out.insert(beat_out.size(), o);
    do begin
      digs.push_front(ASCII_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) begin
      o.out_byte = digs[i];
      beat_out.insert(beat_out.size(), o);
    end
  endfunction

  function automatic void encode_beat(input in_t b);
    beat_out.delete();
    if (run_len != 0 && (b.in_byte != run_char || run_len >= RUN_CAP)) begin
      emit_run();
      run_len = 0;
    end
    if (run_len == 0) begin
      run_char = b.in_byte;
      run_len  = 1;
    end else begin
      run_len++;
    end
    if (b.end_of_string) begin
      emit_run();
      beat_out[beat_out.size() - 1].string_done = 1'b1;
      run_char = 8'h00;
      run_len  = 0;
    end
    if (beat_out.size() != 0) begin
      beat_out[beat_out.size() - 1].last_of_item = 1'b1;
    end
    foreach (beat_out[i]) expected_bytes.insert(expected_bytes.size(), beat_out[i]);
  endfunction

  // driver and receiver: everything changes on the falling edge
  always @(negedge clk) begin
    bit calm;
    calm = (pending_beats.size() < 40);
    if (!calm && $urandom_range(0, 63) == 0) idle_en = !idle_en;
    if (rst) begin
      item_valid   <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      if (!item_valid || beat_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain && expected_bytes.size() != 0)) begin
          item       <= pending_beats[0].beat;
          item_valid <= 1'b1;
          pending_beats.pop_front();
          if (idle_en && !calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          item_valid <= 1'b0;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (idle_en && !calm && $urandom_range(0, 3) == 0) recv_stall = $urandom_range(1, 5);
      end
    end
  end

  // monitor: beats are sampled on the rising edge
  always @(posedge clk) begin
    out_t want;
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("FAIL");
      $finish;
    end else begin
      beat_taken = 1'b0;
      if (!rst) begin
        if (item_valid && item_ready) begin
          beat_taken = 1'b1;
          encode_beat(item);
        end
        if (result_valid && result_ready) begin
          if (expected_bytes.size() == 0) begin
            $error("unexpected result beat: out_byte %h", result.out_byte);
            errors++;
          end else begin
            want = expected_bytes.pop_front();
            if (result.out_byte !== want.out_byte) begin
              $error("out_byte: expected %h, got %h", want.out_byte, result.out_byte);
              errors++;
            end
            if (result.last_of_item !== want.last_of_item) begin
              $error("last_of_item: expected %b, got %b", want.last_of_item,
                     result.last_of_item);
              errors++;
            end
            if (result.string_done !== want.string_done) begin
              $error("string_done: expected %b, got %b", want.string_done,
                     result.string_done);
              errors++;
            end
          end
        end
      end
    end
  end

  initial begin
    logic [7:0] c;
    int         n_runs;
    int         len;
    int         start_cnt;
    bit         noise;
    bit         hold_next;

    // directed: extreme bytes, single-byte strings, change on the last byte,
    // same byte on the last byte, two-digit length
    add_beat(8'h00, 1'b1, 1'b0);
    add_beat(8'hFF, 1'b1, 1'b0);
    add_beat("a", 1'b0, 1'b0);
    add_beat("a", 1'b0, 1'b0);
    add_beat("b", 1'b1, 1'b0);
    add_beat("x", 1'b0, 1'b0);
    add_beat("x", 1'b0, 1'b0);
    add_beat("x", 1'b1, 1'b0);
    for (int k = 0; k < 10; k++) add_beat("7", k == 9, 1'b0);
    add_beat(8'h30, 1'b0, 1'b0);
    add_beat(8'h31, 1'b1, 1'b0);

    // random strings, mostly short runs of random bytes or bytes from a small alphabet
    start_cnt = pending_beats.size();
    hold_next = 1'b1;
    while (pending_beats.size() - start_cnt < N_RANDOM) begin
      n_runs = $urandom_range(1, 6);
      noise  = ($urandom_range(0, 4) == 0);
      for (int r = 0; r < n_runs; r++) begin
        if (noise || $urandom_range(0, 1) == 0) c = 8'($urandom_range(0, 255));
        else c = 8'($urandom_range(8'h41, 8'h44));
        if (noise) len = 1;
        else begin
          case ($urandom_range(0, 19))
            0:          len = $urandom_range(90, 130);
            1, 2, 3, 4: len = $urandom_range(4, 15);
            default:    len = $urandom_range(1, 3);
          endcase
        end
        for (int k = 0; k < len; k++) begin
          add_beat(c, (r == n_runs - 1) && (k == len - 1), hold_next);
          hold_next = 1'b0;
        end
      end
      if (pending_beats.size() - start_cnt > N_RANDOM / 2 &&
          pending_beats.size() - start_cnt - n_runs <= N_RANDOM / 2)
        hold_next = 1'b1;
    end

    cycle_limit = 64 * longint'(pending_beats.size()) + 100000;

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_beats.size() != 0 || item_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (expected_bytes.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
